// ----- hdl/u8dec_pkg.sv -----
package u8dec_pkg;

    // Stream payload widths
    localparam int unsigned InByteW   = 8;
    localparam int unsigned CodeW     = 16;
    localparam int unsigned CountW    = 16;
    localparam int unsigned LeftW     = 2;
    localparam int unsigned OutFieldW = CodeW + 1 + LeftW + CountW;
    localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

    // APB register map
    localparam int unsigned ApbAddrW  = 3;
    localparam int unsigned ApbDataW  = 32;
    localparam logic        RegIdxSkipNul = 1'b0;

    // Byte field masks
    localparam logic [7:0] MaskLead3  = 8'h0F;
    localparam logic [7:0] MaskLead2  = 8'h1F;
    localparam logic [7:0] MaskCont   = 8'h3F;
    localparam logic [1:0] ContTag    = 2'b10;

    localparam logic [CountW-1:0] CountMax = '1;

    typedef logic [1:0]        t_pend;
    typedef logic [CodeW-1:0]  t_code;
    typedef logic [CountW-1:0] t_count;

endpackage

// ----- hdl/utf8_to_ucs2_decoder.sv -----
// UTF-8 to 16-bit code point decoder.
//
// Input stream: one UTF-8 byte per beat in i_s_tdata[7:0]; i_s_tlast marks the
// last byte of a string. Output stream: one beat per completed character or
// per end-of-string byte. o_m_tuser flags a completed character, o_m_tlast
// marks the end-of-string result, which also carries the sticky error, the
// leftover byte count of an unfinished sequence and the saturating count.
// Bytes that complete nothing and are not last produce no output beat.
//
// Throughput is one byte per cycle while the receiver takes results: the
// decode step is a few masks and a 6-bit shift between the input register
// and the result register. o_m_tvalid rises once a byte that produces a beat
// has moved from the input register into the result register.
// When the receiver stalls, the result register holds, the input register
// fills, and o_s_tready drops only once both are occupied.
//
// Reset (synchronous, i_rst_n low) empties both stages, clears the string
// state and sets skip_nul to 0. The skip_nul register sits at APB address 0
// and should be written only while the stream is idle.
module utf8_to_ucs2_decoder
    import u8dec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [InByteW-1:0]  i_s_tdata,    // [7:0] data_byte
    input  logic                i_s_tlast,    // end_of_string

    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [15:0] code_point, [16] decode_error, [18:17] leftover_bytes,
    // [34:19] decoded_count, upper bits zero
    output logic [OutDataW-1:0] o_m_tdata,
    output logic                o_m_tuser,    // has_char
    output logic                o_m_tlast,    // done_res

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    // Configuration
    logic r_skip_nul;

    // Input stage
    logic               r_in_valid;
    logic [InByteW-1:0] r_in_byte;
    logic               r_in_last;

    // String state
    t_pend  r_pending, n_pending;
    t_pend  r_seq_len, n_seq_len;
    t_code  r_partial, n_partial;
    logic   r_err,     n_err;
    t_count r_count,   n_count;

    // Result stage
    logic   r_out_valid;
    t_code  r_out_cp;
    logic   r_out_has, r_out_done, r_out_err;
    t_pend  r_out_left;
    t_count r_out_count;

    // Decode outputs
    logic   got, produce;
    t_code  cp;
    t_pend  left;
    t_pend  pend_dec;

    logic out_free, advance, in_accept;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // APB register file
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[ApbAddrW-1] == RegIdxSkipNul) begin
            prdata[0] = r_skip_nul;
        end
    end

    // Decode step for the byte in the input register
    always_comb begin
        n_pending = r_pending;
        n_seq_len = r_seq_len;
        n_partial = r_partial;
        n_err     = r_err;
        n_count   = r_count;
        got       = 1'b0;
        cp        = '0;
        left      = '0;
        pend_dec  = r_pending - t_pend'(1);

        if (r_pending != '0) begin
            // following byte: always consumed
            if (r_in_byte[7:6] != ContTag) begin
                n_err = 1'b1;
            end
            n_partial = {r_partial[CodeW-7:0], r_in_byte[5:0] & MaskCont[5:0]};
            n_pending = pend_dec;
            if (pend_dec == '0) begin
                got       = 1'b1;
                cp        = n_partial;
                n_partial = '0;
                n_seq_len = '0;
            end
        end else if (r_in_byte[7]) begin
            if (r_in_byte[6]) begin
                if (r_in_byte[5]) begin
                    n_partial = t_code'(r_in_byte & MaskLead3);
                    n_pending = 2'd2;
                    n_seq_len = 2'd3;
                end else begin
                    n_partial = t_code'(r_in_byte & MaskLead2);
                    n_pending = 2'd1;
                    n_seq_len = 2'd2;
                end
            end else begin
                // stray continuation byte
                n_err = 1'b1;
            end
        end else if (r_in_byte != '0 || !r_skip_nul) begin
            got = 1'b1;
            cp  = t_code'(r_in_byte);
        end

        if (got && r_count != CountMax) begin
            n_count = r_count + t_count'(1);
        end

        if (n_pending != '0 && n_seq_len > n_pending) begin
            left = n_seq_len - n_pending;
        end

        produce = got || r_in_last;
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_nul  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_seq_len   <= '0;
            r_partial   <= '0;
            r_err       <= 1'b0;
            r_count     <= '0;
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[ApbAddrW-1] == RegIdxSkipNul) begin
                r_skip_nul <= pwdata[0];
            end

            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= produce;
                if (r_in_last) begin
                    r_pending <= '0;
                    r_seq_len <= '0;
                    r_partial <= '0;
                    r_err     <= 1'b0;
                    r_count   <= '0;
                end else begin
                    r_pending <= n_pending;
                    r_seq_len <= n_seq_len;
                    r_partial <= n_partial;
                    r_err     <= n_err;
                    r_count   <= n_count;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance) begin
            r_out_cp    <= cp;
            r_out_has   <= got;
            r_out_done  <= r_in_last;
            r_out_err   <= r_in_last ? n_err : 1'b0;
            r_out_left  <= r_in_last ? left : '0;
            r_out_count <= r_in_last ? n_count : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_done;
    assign o_m_tdata  = {{(OutDataW - OutFieldW){1'b0}},
                         r_out_count, r_out_left, r_out_err, r_out_cp};

`ifndef SYNTHESIS
    // A result beat is either a character or an end-of-string report
    a_beat_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_has || r_out_done))
        else $error("result beat with neither character nor end of string");

    // Report fields are zero outside the end-of-string beat
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done)
            |-> (!r_out_err && r_out_left == '0 && r_out_count == '0))
        else $error("report fields set on a non-final beat");

    // Pending count never exceeds the sequence length
    a_pend_vs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != 2'd3) && (r_pending == '0 || r_seq_len > r_pending))
        else $error("inconsistent sequence state");

    // String state is cleared after the end-of-string byte is processed
    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_pending == '0 && r_count == '0 && !r_err))
        else $error("string state not cleared at end of string");

    // No character means a zero code point
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_cp == '0))
        else $error("code point set without a character");
`endif

endmodule

// ----- bench/utf8_to_ucs2_decoder_tb.sv -----
`timescale 1ns / 100ps

module utf8_to_ucs2_decoder_tb;
    import u8dec_pkg::*;

    localparam int unsigned WdLimit     = 3000;
    localparam int unsigned RndPhases   = 4;
    localparam int unsigned PhaseBytes  = 440;
    localparam int unsigned HoldAtBeat  = 300;
    localparam int unsigned HoldCycles  = 400;

    // one decoded result beat, field by field
    typedef struct packed {
        t_code        code;
        logic         has_char;
        logic         done;
        logic         err;
        logic [LeftW-1:0] left;
        t_count       count;
    } dec_result_t;

    // directed row: a byte, or a skip_nul write when cfg is set
    typedef struct {
        logic [7:0]  b;
        logic        eos;
        bit          cfg;
        bit          typed;
        dec_result_t res;
    } stim_row_t;

    typedef enum logic [2:0] {
        ChAscii, ChTwo, ChThree, ChFour, ChStray, ChBadFollow, ChNoise
    } char_kind_t;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [InByteW-1:0]  i_s_tdata  = '0;
    logic                i_s_tlast  = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OutDataW-1:0] o_m_tdata;
    logic                o_m_tuser;
    logic                o_m_tlast;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ApbAddrW-1:0] paddr      = '0;
    logic [ApbDataW-1:0] pwdata     = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    // side info travelling with each input beat
    bit          row_typed = 1'b0;
    dec_result_t row_res   = '0;

    // decoder mirror: string state and register copy
    t_pend       pend_q;
    logic [1:0]  seq_len_q;
    t_code       partial_q;
    logic        err_q;
    t_count      chars_q;
    logic        skip_nul_q;

    dec_result_t pending_results [$];
    int unsigned n_fail    = 0;
    int unsigned rx_beats  = 0;
    int unsigned idle_cnt  = 0;
    int unsigned rx_hold   = 0;
    bit          hold_done = 1'b0;
    bit          quiet     = 1'b0;

    utf8_to_ucs2_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // clear per-string state of the mirror
    function automatic void clear_string();
        pend_q    = '0;
        seq_len_q = '0;
        partial_q = '0;
        err_q     = 1'b0;
        chars_q   = '0;
    endfunction

    // advance the mirror by one byte; returns 1 when a result beat is due
    function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                       output dec_result_t r);
        bit    got;
        t_code cp;
        got = 1'b0;
        cp  = '0;
        r   = '0;
        if (pend_q != 0) begin
            if (b[7:6] != ContTag)
                err_q = 1'b1;
            partial_q = {partial_q[CodeW-7:0], b[5:0] & MaskCont[5:0]};
            pend_q    = pend_q - t_pend'(1);
            if (pend_q == 0) begin
                got       = 1'b1;
                cp        = partial_q;
                partial_q = '0;
                seq_len_q = '0;
            end
        end else if (b[7]) begin
            if (b[6]) begin
                if (b[5]) begin
                    partial_q = t_code'(b & MaskLead3);
                    pend_q    = 2'd2;
                    seq_len_q = 2'd3;
                end else begin
                    partial_q = t_code'(b & MaskLead2);
                    pend_q    = 2'd1;
                    seq_len_q = 2'd2;
                end
            end else begin
                // stray continuation lead
                err_q = 1'b1;
            end
        end else if (b != 8'h00 || !skip_nul_q) begin
            got = 1'b1;
            cp  = t_code'(b);
        end

        if (got && chars_q != CountMax)
            chars_q = chars_q + t_count'(1);
        if (!got && !eos)
            return 1'b0;

        r.code     = cp;
        r.has_char = got;
        r.done     = eos;
        if (eos) begin
            r.err   = err_q;
            r.left  = (pend_q != 0 && seq_len_q > pend_q) ? seq_len_q - pend_q : 2'd0;
            r.count = chars_q;
            clear_string();
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    task automatic cmp_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_fail++;
        end
    endtask

    // offer one input beat and hold it until accepted
    task automatic send_beat(input logic [7:0] b, input logic eos, input bit typed,
                             input dec_result_t res);
        if (!quiet && $urandom_range(99) < 18) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        row_typed  <= typed;
        row_res    <= res;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // let the stream drain, then write skip_nul over APB
    task automatic write_skip_nul(input logic v);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ApbAddrW'(4 * int'(RegIdxSkipNul));
        pwdata  <= ApbDataW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        skip_nul_q = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // one string of random characters, mostly well formed
    task automatic send_random_string(output int unsigned n_bytes);
        logic [7:0] seq [$];
        int         n_chars;
        int         roll;
        char_kind_t kind;
        logic [7:0] lead;
        n_chars = $urandom_range(1, 12);
        for (int c = 0; c < n_chars; c++) begin
            roll = $urandom_range(99);
            kind = roll < 35 ? ChAscii : roll < 55 ? ChTwo : roll < 72 ? ChThree :
                   roll < 82 ? ChFour : roll < 88 ? ChStray : roll < 96 ? ChBadFollow :
                   ChNoise;
            case (kind)
                ChAscii: begin
                    seq.push_back(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(127)));
                end
                ChTwo: begin
                    seq.push_back(8'hC0 | 8'($urandom_range(31)));
                    seq.push_back(cont_byte());
                end
                ChThree: begin
                    seq.push_back(8'hE0 | 8'($urandom_range(15)));
                    seq.push_back(cont_byte());
                    seq.push_back(cont_byte());
                end
                ChFour: begin
                    seq.push_back(8'hF0 | 8'($urandom_range(15)));
                    seq.push_back(cont_byte());
                    seq.push_back(cont_byte());
                end
                ChStray: begin
                    seq.push_back(cont_byte());
                end
                ChBadFollow: begin
                    lead = 8'hC0 | 8'($urandom_range(63));
                    seq.push_back(lead);
                    seq.push_back(8'($urandom_range(255)));
                    if (lead[5])
                        seq.push_back(8'($urandom_range(255)));
                end
                default: begin
                    seq.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        // sometimes end the string inside a sequence
        if ($urandom_range(9) == 0) begin
            lead = 8'hC0 | 8'($urandom_range(63));
            seq.push_back(lead);
            if (lead[5] && $urandom_range(1) == 1)
                seq.push_back(cont_byte());
        end
        foreach (seq[i])
            send_beat(seq[i], i == seq.size() - 1, 1'b0, '0);
        n_bytes = seq.size();
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && rx_beats == HoldAtBeat) begin
            rx_hold    <= HoldCycles;
            hold_done  <= 1'b1;
            i_m_tready <= 1'b0;
        end else if (quiet) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 22);
        end
    end

    // beat monitor: check output beats, predict on input beats
    always @(posedge i_clk) begin
        dec_result_t want;
        dec_result_t pred;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                rx_beats <= rx_beats + 1;
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("code_point", want.code, o_m_tdata[15:0]);
                    cmp_field("has_char", want.has_char, o_m_tuser);
                    cmp_field("done_res", want.done, o_m_tlast);
                    cmp_field("decode_error", want.err, o_m_tdata[16]);
                    cmp_field("leftover_bytes", want.left, o_m_tdata[18:17]);
                    cmp_field("decoded_count", want.count, o_m_tdata[34:19]);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                if (decode_byte(i_s_tdata, i_s_tlast, pred))
                    pending_results.push_back(row_typed ? row_res : pred);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt == WdLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        stim_row_t   dir_tab [$];
        int unsigned sent;
        int unsigned n_bytes;

        skip_nul_q = 1'b0;
        clear_string();

        // directed rows, skip_nul at reset value first
        dir_tab.push_back('{8'h41, 1'b0, 1'b0, 1'b1, '{16'h0041, 1'b1, 1'b0, 1'b0, 2'd0, 16'd0}});
        dir_tab.push_back('{8'h00, 1'b0, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 2'd0, 16'd0}});
        dir_tab.push_back('{8'h7F, 1'b0, 1'b0, 1'b1, '{16'h007F, 1'b1, 1'b0, 1'b0, 2'd0, 16'd0}});
        dir_tab.push_back('{8'hC3, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hA9, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hE2, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'h82, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hAC, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hEF, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hBF, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hBF, 1'b0, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b0, 1'b0, 2'd0, 16'd0}});
        // four-byte lead decoded as a three-byte sequence
        dir_tab.push_back('{8'hF7, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'h80, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'h80, 1'b0, 1'b0, 1'b0, '0});
        // stray continuation, then a bad following byte
        dir_tab.push_back('{8'h80, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hC2, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'h41, 1'b0, 1'b0, 1'b0, '0});
        // end of string right after a lead: one byte left over
        dir_tab.push_back('{8'hE0, 1'b1, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b1, 2'd1, 16'd8}});
        dir_tab.push_back('{8'hE0, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'h80, 1'b1, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 2'd2, 16'd0}});
        dir_tab.push_back('{8'h00, 1'b1, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b0, 2'd0, 16'd1}});
        // NUL suppressed with skip_nul set
        dir_tab.push_back('{8'h01, 1'b0, 1'b1, 1'b0, '0});
        dir_tab.push_back('{8'h00, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'h00, 1'b1, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 2'd0, 16'd0}});
        dir_tab.push_back('{8'h41, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hC3, 1'b1, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hC3, 1'b0, 1'b0, 1'b0, '0});
        dir_tab.push_back('{8'hA9, 1'b1, 1'b0, 1'b0, '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg)
                write_skip_nul(dir_tab[i].b[0]);
            else
                send_beat(dir_tab[i].b, dir_tab[i].eos, dir_tab[i].typed, dir_tab[i].res);
        end

        // random strings, skip_nul toggling between phases
        for (int unsigned ph = 0; ph < RndPhases; ph++) begin
            write_skip_nul(ph[0] ? 1'b0 : 1'b1);
            quiet = (ph == 2);
            sent  = 0;
            while (sent < PhaseBytes) begin
                send_random_string(n_bytes);
                sent += n_bytes;
            end
        end
        quiet = 1'b0;

        // drain and settle
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
